@@ sv/jbsr_pkg.sv @@
// shared types and constants for the joybus slave register device
package jbsr_pkg;

    localparam logic       FUNC_WRITE   = 1'b0;
    localparam logic       FUNC_COMMAND = 1'b1;

    localparam logic [7:0] BUS_RESET    = 8'hFF;
    localparam logic [7:0] BUS_POLL     = 8'h00;
    localparam logic [7:0] BUS_TRANSMIT = 8'h14;
    localparam logic [7:0] BUS_RECEIVE  = 8'h15;

    // device id sent after reset and poll
    localparam logic [7:0] ID_FIRST  = 8'h00;
    localparam logic [7:0] ID_SECOND = 8'h04;

    typedef enum logic [2:0] {
        REG_CONTROL = 3'd0,
        REG_STATUS  = 3'd1,
        REG_TX_LOW  = 3'd2,
        REG_TX_HIGH = 3'd3,
        REG_RX_LOW  = 3'd4,
        REG_RX_HIGH = 3'd5
    } reg_sel_t;

    localparam logic [6:0] CTRL_RESET_EV = 7'h01;
    localparam logic [6:0] CTRL_RX_EV    = 7'h02;
    localparam logic [6:0] CTRL_TX_EV    = 7'h04;
    localparam logic [6:0] CTRL_IRQ_EN   = 7'h40;
    localparam logic [5:0] STAT_RX_FULL  = 6'h02;
    localparam logic [5:0] STAT_TX_PEND  = 6'h08;
    localparam logic [5:0] STAT_CPU_MASK = 6'h30;

    localparam logic [5:0] BITS_OTHER = 6'd9;
    localparam logic [5:0] BITS_POLL  = 6'd34;
    localparam logic [5:0] BITS_XFER  = 6'd50;

    localparam logic [7:0] BIT_CYCLES_RESET = 8'd75;

    localparam int MAX_REPLY = 5;

    typedef struct packed {
        logic        func;
        logic [2:0]  reg_select;
        logic [15:0] write_value;
        logic [7:0]  command;
        logic [31:0] recv_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  reply_byte;
        logic        reply_valid;
        logic        last;
        logic        irq;
        logic [13:0] line_cycles;
        logic [15:0] stored_value;
        logic [6:0]  control_now;
        logic [5:0]  status_now;
    } out_item_t;

    // one classified item waiting for the reply sequencer
    typedef struct packed {
        logic [2:0]                 count;
        logic                       reply_valid;
        logic [MAX_REPLY-1:0][7:0]  bytes;
        logic                       irq;
        logic [13:0]                line_cycles;
        logic [15:0]                stored_value;
        logic [6:0]                 control_now;
        logic [5:0]                 status_now;
    } job_t;

endpackage

@@ sv/jbsr_front.sv @@
// front end: takes items, updates the register file and builds reply jobs
module jbsr_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    input  logic              accept,
    input  jbsr_pkg::in_item_t item,
    output jbsr_pkg::job_t    job
);

    logic [7:0]  bit_cycles_reg;
    logic [6:0]  control_reg, control_next;
    logic [5:0]  status_reg, status_next;
    logic [15:0] tx_low_reg, tx_low_next;
    logic [15:0] tx_high_reg, tx_high_next;
    logic [15:0] rx_low_reg, rx_low_next;
    logic [15:0] rx_high_reg, rx_high_next;
    logic [5:0]  line_bits;

    always_comb
    begin
        control_next = control_reg;
        status_next  = status_reg;
        tx_low_next  = tx_low_reg;
        tx_high_next = tx_high_reg;
        rx_low_next  = rx_low_reg;
        rx_high_next = rx_high_reg;
        job              = '0;
        job.count        = 3'd1;
        line_bits        = jbsr_pkg::BITS_OTHER;

        if (item.func == jbsr_pkg::FUNC_WRITE)
        begin
            case (item.reg_select)
                jbsr_pkg::REG_CONTROL:
                begin
                    // irq enable copies, event flags clear where written one
                    control_next = (item.write_value[6:0] & jbsr_pkg::CTRL_IRQ_EN)
                        | (control_reg & ~{4'b0, item.write_value[2:0]}
                           & ~jbsr_pkg::CTRL_IRQ_EN);
                    job.stored_value = {9'b0, control_next};
                end
                jbsr_pkg::REG_STATUS:
                begin
                    status_next = (item.write_value[5:0] & jbsr_pkg::STAT_CPU_MASK)
                        | (status_reg & ~jbsr_pkg::STAT_CPU_MASK);
                    job.stored_value = {10'b0, status_next};
                end
                jbsr_pkg::REG_TX_LOW:
                begin
                    tx_low_next      = item.write_value;
                    status_next      = status_reg | jbsr_pkg::STAT_TX_PEND;
                    job.stored_value = item.write_value;
                end
                jbsr_pkg::REG_TX_HIGH:
                begin
                    tx_high_next     = item.write_value;
                    status_next      = status_reg | jbsr_pkg::STAT_TX_PEND;
                    job.stored_value = item.write_value;
                end
                jbsr_pkg::REG_RX_LOW:
                begin
                    rx_low_next      = item.write_value;
                    job.stored_value = item.write_value;
                end
                jbsr_pkg::REG_RX_HIGH:
                begin
                    rx_high_next     = item.write_value;
                    job.stored_value = item.write_value;
                end
                default:
                begin
                    job.stored_value = '0;
                end
            endcase
            job.line_cycles = '0;
        end
        else
        begin
            case (item.command)
                jbsr_pkg::BUS_RESET, jbsr_pkg::BUS_POLL:
                begin
                    if (item.command == jbsr_pkg::BUS_RESET)
                    begin
                        control_next = control_reg | jbsr_pkg::CTRL_RESET_EV;
                        job.irq      = |(control_reg & jbsr_pkg::CTRL_IRQ_EN);
                    end
                    job.count       = 3'd3;
                    job.reply_valid = 1'b1;
                    job.bytes[0]    = jbsr_pkg::ID_FIRST;
                    job.bytes[1]    = jbsr_pkg::ID_SECOND;
                    job.bytes[2]    = {2'b0, status_reg};
                    line_bits       = jbsr_pkg::BITS_POLL;
                end
                jbsr_pkg::BUS_RECEIVE:
                begin
                    control_next    = control_reg | jbsr_pkg::CTRL_RX_EV;
                    status_next     = status_reg | jbsr_pkg::STAT_RX_FULL;
                    rx_low_next     = item.recv_data[15:0];
                    rx_high_next    = item.recv_data[31:16];
                    job.count       = 3'd1;
                    job.reply_valid = 1'b1;
                    job.bytes[0]    = {2'b0, status_next};
                    job.irq         = |(control_reg & jbsr_pkg::CTRL_IRQ_EN);
                    line_bits       = jbsr_pkg::BITS_XFER;
                end
                jbsr_pkg::BUS_TRANSMIT:
                begin
                    control_next    = control_reg | jbsr_pkg::CTRL_TX_EV;
                    status_next     = status_reg & ~jbsr_pkg::STAT_TX_PEND;
                    job.count       = 3'd5;
                    job.reply_valid = 1'b1;
                    job.bytes[0]    = tx_low_reg[7:0];
                    job.bytes[1]    = tx_low_reg[15:8];
                    job.bytes[2]    = tx_high_reg[7:0];
                    job.bytes[3]    = tx_high_reg[15:8];
                    job.bytes[4]    = {2'b0, status_next};
                    job.irq         = |(control_reg & jbsr_pkg::CTRL_IRQ_EN);
                    line_bits       = jbsr_pkg::BITS_XFER;
                end
                default:
                begin
                    line_bits = jbsr_pkg::BITS_OTHER;
                end
            endcase
            job.line_cycles = {8'b0, line_bits} * {6'b0, bit_cycles_reg};
        end

        job.control_now = control_next;
        job.status_now  = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cycles_reg <= jbsr_pkg::BIT_CYCLES_RESET;
            control_reg    <= '0;
            status_reg     <= '0;
            tx_low_reg     <= '0;
            tx_high_reg    <= '0;
            rx_low_reg     <= '0;
            rx_high_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bit_cycles_reg <= cfg_data;
            end
            if (accept)
            begin
                control_reg <= control_next;
                status_reg  <= status_next;
                tx_low_reg  <= tx_low_next;
                tx_high_reg <= tx_high_next;
                rx_low_reg  <= rx_low_next;
                rx_high_reg <= rx_high_next;
            end
        end
    end

endmodule

@@ sv/jbsr_queue.sv @@
// short job queue between the front end and the reply sequencer
module jbsr_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  jbsr_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output jbsr_pkg::job_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    jbsr_pkg::job_t        slot_reg [DEPTH];
    logic [PW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         count_reg, count_next;

    assign full       = (count_reg == FULL_COUNT);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/jbsr_back.sv @@
// reply sequencer: walks the head job byte by byte into the output register
module jbsr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  jbsr_pkg::job_t      head,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output jbsr_pkg::out_item_t res_item
);

    logic [2:0]          idx_reg, idx_next;
    logic                res_valid_reg, res_valid_next;
    jbsr_pkg::out_item_t res_item_reg;
    jbsr_pkg::out_item_t item;
    logic                load;
    logic                is_last;

    assign is_last = (idx_reg == head.count - 3'd1);
    assign load    = head_valid && (!res_valid_reg || res_ready);
    assign pop     = load && is_last;

    always_comb
    begin
        item.reply_byte   = head.bytes[idx_reg];
        item.reply_valid  = head.reply_valid;
        item.last         = is_last;
        item.irq          = is_last && head.irq;
        item.line_cycles  = head.line_cycles;
        item.stored_value = head.stored_value;
        item.control_now  = head.control_now;
        item.status_now   = head.status_now;
    end

    always_comb
    begin
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
            idx_next       = is_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_item_reg <= item;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // between jobs the byte index rests at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == 3'd0)
        else $error("byte index left mid-job with no job queued");

    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < head.count)
        else $error("byte index past job length");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_item_reg.irq |-> res_item_reg.last)
        else $error("irq on a transfer that is not the last of its job");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> res_valid_reg && res_item_reg.last)
        else $error("job retired without its last transfer in the output");

endmodule

@@ sv/joybus_slave_register_device.sv @@
// top level of the joybus slave register device
//
//  channel  | signals                      | payload
//  ---------+------------------------------+---------------------
//  input    | cmd_valid / cmd_ready        | cmd_item (in_item_t)
//  result   | res_valid / res_ready        | res_item (out_item_t)
//  config   | cfg_we                       | cfg_data (bit_cycles)
//
//  an input item is classified and applied to the registers in the cycle it is
//  taken; its reply job then gives one result transfer per cycle while results do not
//  stall, 1 to 5 per item, so the reply sequencer sets the rate.
//  the job queue lets input keep flowing while results stall; cmd_ready drops
//  only when the queue is full. reset clears the registers and sets bit_cycles
//  to 75.
module joybus_slave_register_device
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  jbsr_pkg::in_item_t  cmd_item,
    output logic                res_valid,
    input  logic                res_ready,
    output jbsr_pkg::out_item_t res_item
);

    jbsr_pkg::job_t new_job;
    jbsr_pkg::job_t head;
    logic           accept;
    logic           full;
    logic           head_valid;
    logic           pop;

    assign cmd_ready = !full;
    assign accept    = cmd_valid && cmd_ready;

    jbsr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .item     (cmd_item),
        .job      (new_job)
    );

    jbsr_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (new_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    jbsr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

endmodule

@@ bench/tb_joybus_slave_register_device.sv @@
// testbench for the joybus slave register device: directed and random traffic against a predictor
module tb_joybus_slave_register_device;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam logic [6:0] CTRL_EVENTS = jbsr_pkg::CTRL_RESET_EV | jbsr_pkg::CTRL_RX_EV
                                       | jbsr_pkg::CTRL_TX_EV;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [7:0]          cfg_data = 8'd0;
    logic                cmd_valid = 1'b0;
    logic                cmd_ready;
    jbsr_pkg::in_item_t  cmd_item = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    jbsr_pkg::out_item_t res_item;

    // predictor copy of the block's registers
    logic [6:0]  ctrl_shadow = '0;
    logic [5:0]  status_shadow = '0;
    logic [15:0] tx_low_shadow = '0;
    logic [15:0] tx_high_shadow = '0;
    logic [15:0] rx_low_shadow = '0;
    logic [15:0] rx_high_shadow = '0;
    logic [7:0]  bit_cycles_shadow = jbsr_pkg::BIT_CYCLES_RESET;

    jbsr_pkg::out_item_t pending_replies[$];
    int        fail_count = 0;
    int        items_sent = 0;
    int        replies_checked = 0;
    int        cycle_count = 0;
    int        hold_req = 0;

    joybus_slave_register_device DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_item (cmd_item),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_item (res_item)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, pending_replies.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // apply one accepted item to the shadow registers and queue its replies
    task automatic predict_replies(input jbsr_pkg::in_item_t it);
        logic [7:0]  bytes [jbsr_pkg::MAX_REPLY];
        int          n;
        logic [5:0]  bits;
        logic        irq_out;
        logic [13:0] cycles;
        jbsr_pkg::out_item_t r;
        n = 0;
        bits = jbsr_pkg::BITS_OTHER;
        irq_out = 1'b0;
        r = '0;
        if (it.func == jbsr_pkg::FUNC_WRITE)
        begin
            case (jbsr_pkg::reg_sel_t'(it.reg_select))
                jbsr_pkg::REG_CONTROL:
                begin
                    ctrl_shadow = (it.write_value[6:0] & jbsr_pkg::CTRL_IRQ_EN)
                                | (ctrl_shadow & ~(it.write_value[6:0] & CTRL_EVENTS)
                                   & ~jbsr_pkg::CTRL_IRQ_EN);
                    r.stored_value = {9'd0, ctrl_shadow};
                end
                jbsr_pkg::REG_STATUS:
                begin
                    status_shadow = (it.write_value[5:0] & jbsr_pkg::STAT_CPU_MASK)
                                  | (status_shadow & ~jbsr_pkg::STAT_CPU_MASK);
                    r.stored_value = {10'd0, status_shadow};
                end
                jbsr_pkg::REG_TX_LOW:
                begin
                    tx_low_shadow = it.write_value;
                    status_shadow |= jbsr_pkg::STAT_TX_PEND;
                    r.stored_value = it.write_value;
                end
                jbsr_pkg::REG_TX_HIGH:
                begin
                    tx_high_shadow = it.write_value;
                    status_shadow |= jbsr_pkg::STAT_TX_PEND;
                    r.stored_value = it.write_value;
                end
                jbsr_pkg::REG_RX_LOW:
                begin
                    rx_low_shadow = it.write_value;
                    r.stored_value = it.write_value;
                end
                jbsr_pkg::REG_RX_HIGH:
                begin
                    rx_high_shadow = it.write_value;
                    r.stored_value = it.write_value;
                end
                default: ;
            endcase
            r.last = 1'b1;
            r.control_now = ctrl_shadow;
            r.status_now = status_shadow;
            pending_replies.push_back(r);
            return;
        end

        case (it.command)
            jbsr_pkg::BUS_RESET, jbsr_pkg::BUS_POLL:
            begin
                if (it.command == jbsr_pkg::BUS_RESET)
                begin
                    ctrl_shadow |= jbsr_pkg::CTRL_RESET_EV;
                    irq_out = |(ctrl_shadow & jbsr_pkg::CTRL_IRQ_EN);
                end
                bytes[0] = jbsr_pkg::ID_FIRST;
                bytes[1] = jbsr_pkg::ID_SECOND;
                bytes[2] = {2'b00, status_shadow};
                n = 3;
                bits = jbsr_pkg::BITS_POLL;
            end
            jbsr_pkg::BUS_RECEIVE:
            begin
                ctrl_shadow |= jbsr_pkg::CTRL_RX_EV;
                status_shadow |= jbsr_pkg::STAT_RX_FULL;
                rx_low_shadow = it.recv_data[15:0];
                rx_high_shadow = it.recv_data[31:16];
                bytes[0] = {2'b00, status_shadow};
                n = 1;
                irq_out = |(ctrl_shadow & jbsr_pkg::CTRL_IRQ_EN);
                bits = jbsr_pkg::BITS_XFER;
            end
            jbsr_pkg::BUS_TRANSMIT:
            begin
                ctrl_shadow |= jbsr_pkg::CTRL_TX_EV;
                status_shadow &= ~jbsr_pkg::STAT_TX_PEND;
                bytes[0] = tx_low_shadow[7:0];
                bytes[1] = tx_low_shadow[15:8];
                bytes[2] = tx_high_shadow[7:0];
                bytes[3] = tx_high_shadow[15:8];
                bytes[4] = {2'b00, status_shadow};
                n = 5;
                irq_out = |(ctrl_shadow & jbsr_pkg::CTRL_IRQ_EN);
                bits = jbsr_pkg::BITS_XFER;
            end
            default: ;
        endcase

        cycles = 14'(bits) * 14'(bit_cycles_shadow);
        r.line_cycles = cycles;
        r.control_now = ctrl_shadow;
        r.status_now = status_shadow;
        if (n == 0)
        begin
            r.last = 1'b1;
            pending_replies.push_back(r);
        end
        for (int i = 0; i < n; i++)
        begin
            r.reply_byte = bytes[i];
            r.reply_valid = 1'b1;
            r.last = (i == n - 1);
            r.irq = r.last ? irq_out : 1'b0;
            pending_replies.push_back(r);
        end
    endtask

    // one input transfer; valid is left high so a following item goes back to back
    task automatic send_item(input jbsr_pkg::in_item_t it);
        cmd_valid <= 1'b1;
        cmd_item <= it;
        do @(posedge clk); while (!cmd_ready);
        predict_replies(it);
        items_sent++;
    endtask

    task automatic pause_input(input int n);
        cmd_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_replies();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (pending_replies.size() != 0);
    endtask

    task automatic set_bit_cycles(input logic [7:0] v);
        drain_replies();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        bit_cycles_shadow = v;
    endtask

    function automatic jbsr_pkg::in_item_t reg_write(input logic [2:0] sel,
                                                     input logic [15:0] v);
        jbsr_pkg::in_item_t it;
        it.func = jbsr_pkg::FUNC_WRITE;
        it.reg_select = sel;
        it.write_value = v;
        it.command = 8'($urandom);
        it.recv_data = $urandom;
        return it;
    endfunction

    function automatic jbsr_pkg::in_item_t bus_cmd(input logic [7:0] c, input logic [31:0] d);
        jbsr_pkg::in_item_t it;
        it.func = jbsr_pkg::FUNC_COMMAND;
        it.reg_select = 3'($urandom);
        it.write_value = 16'($urandom);
        it.command = c;
        it.recv_data = d;
        return it;
    endfunction

    function automatic jbsr_pkg::in_item_t random_item();
        jbsr_pkg::in_item_t it;
        logic [7:0] c;
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    c = jbsr_pkg::BUS_POLL;
            2:       c = jbsr_pkg::BUS_RESET;
            3, 4, 5: c = jbsr_pkg::BUS_TRANSMIT;
            6, 7:    c = jbsr_pkg::BUS_RECEIVE;
            default: c = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 1) == 0)
        begin
            if ($urandom_range(0, 9) == 0)
                it = reg_write(3'($urandom_range(6, 7)), 16'($urandom));
            else
                it = reg_write(3'($urandom_range(0, 5)), 16'($urandom));
        end
        else
            it = bus_cmd(c, $urandom);
        return it;
    endfunction

    task automatic run_traffic(input int n);
        int left;
        int burst;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            repeat (burst) send_item(random_item());
            left -= burst;
            if ($urandom_range(0, 2) != 0)
                pause_input($urandom_range(1, 12));
        end
    endtask

    task automatic test_register_writes();
        send_item(reg_write(jbsr_pkg::REG_CONTROL, 16'hFFFF));
        send_item(reg_write(jbsr_pkg::REG_CONTROL, 16'h0000));
        send_item(reg_write(jbsr_pkg::REG_STATUS, 16'hFFFF));
        send_item(reg_write(jbsr_pkg::REG_TX_LOW, 16'hFFFF));
        send_item(reg_write(jbsr_pkg::REG_TX_HIGH, 16'h0000));
        send_item(reg_write(jbsr_pkg::REG_RX_LOW, 16'hFFFF));
        send_item(reg_write(jbsr_pkg::REG_RX_HIGH, 16'h0000));
        // selects past the last register write nothing
        send_item(reg_write(3'd6, 16'hFFFF));
        send_item(reg_write(3'd7, 16'h1234));
        send_item(reg_write(jbsr_pkg::REG_STATUS, 16'h0000));
    endtask

    task automatic test_bus_commands();
        send_item(bus_cmd(jbsr_pkg::BUS_POLL, 32'h0));
        send_item(bus_cmd(jbsr_pkg::BUS_RESET, 32'h0));
        send_item(bus_cmd(jbsr_pkg::BUS_RECEIVE, 32'hFFFF_FFFF));
        send_item(bus_cmd(jbsr_pkg::BUS_TRANSMIT, 32'h0));
        // unknown commands leave the registers alone
        send_item(bus_cmd(8'h01, 32'h0));
        send_item(bus_cmd(8'hFE, 32'hFFFF_FFFF));
        // interrupt enable on, event flags cleared
        send_item(reg_write(jbsr_pkg::REG_CONTROL, 16'h0047));
        send_item(bus_cmd(jbsr_pkg::BUS_RESET, 32'h0));
        send_item(bus_cmd(jbsr_pkg::BUS_RECEIVE, 32'h0000_0000));
        send_item(reg_write(jbsr_pkg::REG_TX_HIGH, 16'hA55A));
        send_item(bus_cmd(jbsr_pkg::BUS_TRANSMIT, 32'h0));
        send_item(bus_cmd(jbsr_pkg::BUS_POLL, 32'h0));
        send_item(reg_write(jbsr_pkg::REG_CONTROL, 16'h0007));
    endtask

    // receiver holds off while transmits keep coming, so the job queue fills
    task automatic test_result_stall();
        drain_replies();
        hold_req++;
        repeat (14)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(reg_write(jbsr_pkg::REG_TX_LOW, 16'($urandom)));
            else
                send_item(bus_cmd(jbsr_pkg::BUS_TRANSMIT, $urandom));
        end
        drain_replies();
    endtask

    task automatic test_line_timing();
        set_bit_cycles(8'd1);
        run_traffic(60);
        set_bit_cycles(8'd255);
        run_traffic(60);
        set_bit_cycles(8'd0);
        run_traffic(40);
    endtask

    task automatic test_random_mix();
        repeat (3)
        begin
            set_bit_cycles(8'($urandom_range(1, 255)));
            run_traffic(30);
        end
    endtask

    // receiver: checks each result transfer and drives its own stall pattern
    int         stall_mode = 0;
    int         mode_left = 0;
    int         hold_left = 0;
    int         hold_seen = 0;
    logic [7:0] stall_ctr = '0;

    always @(posedge clk)
    begin
        jbsr_pkg::out_item_t want;
        if (hold_req != hold_seen)
        begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_req;
        end

        if (rst_n && res_valid && res_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result at cycle %0d: %h", cycle_count, res_item);
            end
            else
            begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (res_item.reply_byte !== want.reply_byte
                    || res_item.reply_valid !== want.reply_valid
                    || res_item.last !== want.last
                    || res_item.irq !== want.irq
                    || res_item.line_cycles !== want.line_cycles
                    || res_item.stored_value !== want.stored_value
                    || res_item.control_now !== want.control_now
                    || res_item.status_now !== want.status_now)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch at cycle %0d: expected byte %h valid %b last %b ",
                                 cycle_count, want.reply_byte, want.reply_valid, want.last,
                                 "irq %b cycles %0d stored %h ctrl %h status %h; ",
                                 want.irq, want.line_cycles, want.stored_value,
                                 want.control_now, want.status_now,
                                 "got byte %h valid %b last %b irq %b cycles %0d ",
                                 res_item.reply_byte, res_item.reply_valid, res_item.last,
                                 res_item.irq, res_item.line_cycles,
                                 "stored %h ctrl %h status %h",
                                 res_item.stored_value, res_item.control_now,
                                 res_item.status_now);
                end
            end
        end

        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
        end
        else
            mode_left--;
        stall_ctr++;

        if (hold_left != 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       res_ready <= 1'b1;
                1:       res_ready <= 1'($urandom_range(0, 1));
                2:       res_ready <= (stall_ctr[1:0] == 2'd0);
                default: res_ready <= (stall_ctr[2:0] != 3'd7);
            endcase
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_writes();
        test_bus_commands();
        test_result_stall();
        test_line_timing();
        test_random_mix();
        drain_replies();
        repeat (20) @(posedge clk);
        $display("covered %0d input transfers and %0d result transfers in %0d cycles",
                 items_sent, replies_checked, cycle_count);
        $display("register writes, all bus commands, a long result stall and %s",
                 "bit_cycles at reset value, 1, 255, 0 and random values");
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
